@@ rtl/core/fatigue_vote_alarm_controller_core_assert.svh @@
// Assertion helpers used by the core RTL.
`ifndef FATIGUE_VOTE_ALARM_CONTROLLER_CORE_ASSERT_SVH
`define FATIGUE_VOTE_ALARM_CONTROLLER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define FVAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its condition.
`define FVAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/fvac_pkg.sv @@
package fvac_pkg;

	// Block sizing
	localparam int VOTE_WINDOW = 16;
	localparam int SCORE_MAX   = 1000;
	localparam int LOST_FRAMES = 30;
	localparam int FRAME_RATE  = 30;
	localparam int BLINK_DIV   = FRAME_RATE / 4;
	localparam int PERCENT_FULL = 100;

	localparam int POS_W   = $clog2(VOTE_WINDOW);
	localparam int TOT_W   = $clog2(VOTE_WINDOW + 1);
	localparam int PROD_W  = $clog2((VOTE_WINDOW + 1) * 127 + 1);
	localparam int SCORE_W = 10;
	localparam int WVOTE_W = 5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_THR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_RISE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_DECAY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STREAK_THR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_LENGTH = 3'd7;

	// LED patterns
	localparam logic [3:0] LED_ODD  = 4'h5;
	localparam logic [3:0] LED_EVEN = 4'hA;

	typedef struct packed {
		logic [7:0]         confidence_threshold;
		logic [9:0]         warmup_frames;
		logic [6:0]         alarm_ratio_percent;
		logic [9:0]         score_rise;
		logic [9:0]         score_decay;
		logic [9:0]         danger_score;
		logic [7:0]         streak_threshold;
		logic [15:0]        alarm_length;
	} cfg_t;

	typedef struct packed {
		logic       target_present;
		logic       class_is_fatigued;
		logic [7:0] class_confidence;
	} frame_t;

	typedef struct packed {
		logic               alarm_active;
		logic               alarm_started;
		logic               alarm_ended;
		logic               lost_alert;
		logic               target_recovered;
		logic [3:0]         led_drive;
		logic               frame_vote;
		logic [WVOTE_W-1:0] window_votes;
		logic [SCORE_W-1:0] current_score;
		logic [7:0]         current_streak;
	} result_t;

	typedef struct packed {
		logic                   in_alarm;
		logic [VOTE_WINDOW-1:0] vote_window;
		logic [POS_W-1:0]       window_position;
		logic                   window_full;
		logic [TOT_W-1:0]       vote_total;
		logic [7:0]             fatigue_streak;
		logic [SCORE_W-1:0]     score;
		logic [15:0]            lost_frames;
		logic                   lost_reported;
		logic [10:0]            frames_seen;
		logic [15:0]            alarm_frames;
		logic [7:0]             blink_phase;
		logic                   toggle_bit;
		logic [3:0]             led_levels;
	} state_t;

endpackage

@@ rtl/core/fvac_frame_if.sv @@
interface fvac_frame_if;
	logic       valid;
	logic       ready;
	logic       target_present;
	logic       class_is_fatigued;
	logic [7:0] class_confidence;

	modport source (output valid, target_present, class_is_fatigued, class_confidence,
		input ready);
	modport sink (input valid, target_present, class_is_fatigued, class_confidence,
		output ready);
endinterface

@@ rtl/core/fvac_result_if.sv @@
interface fvac_result_if;
	logic        valid;
	logic        ready;
	logic        alarm_active;
	logic        alarm_started;
	logic        alarm_ended;
	logic        lost_alert;
	logic        target_recovered;
	logic [3:0]  led_drive;
	logic        frame_vote;
	logic [4:0]  window_votes;
	logic [9:0]  current_score;
	logic [7:0]  current_streak;

	modport source (output valid, alarm_active, alarm_started, alarm_ended, lost_alert,
		target_recovered, led_drive, frame_vote, window_votes, current_score,
		current_streak, input ready);
	modport sink (input valid, alarm_active, alarm_started, alarm_ended, lost_alert,
		target_recovered, led_drive, frame_vote, window_votes, current_score,
		current_streak, output ready);
endinterface

@@ rtl/core/fatigue_vote_alarm_controller_core.sv @@
// Fatigue vote alarm controller core.
// frame_in carries one frame verdict per transfer (target presence, class,
// Q0.8 confidence); result_out returns exactly one result per frame, in order.
// Both channels transfer on a clock edge with valid and ready high.
// A transferred frame is held in the input stage, processed by the step logic
// and then lands in the result register, where its result is valid; the input
// stage advances only when the result register is free or being taken.
// Throughput is one frame per cycle while result_out is not stalled, with the
// vote window, score and alarm counters updated once per processed frame.
// When result_out stalls, the input stage still takes one more frame; after
// that frame_in.ready drops until the result is taken.
// The cfg_* port writes one register per edge with cfg_wr_en high; write only
// while no frame is in flight.
// arst_n clears all state and the pipeline and restores register defaults;
// no frame needs to wait for any clearing pass after reset.
module fatigue_vote_alarm_controller_core
	import fvac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	fvac_frame_if.sink            frame_in,
	fvac_result_if.source         result_out,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "fatigue_vote_alarm_controller_core_assert.svh"

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	frame_t  frame_s1;
	logic    valid_s1;
	result_t result_nxt;
	result_t result_q;
	logic    out_valid_q;
	logic    accept;
	logic    advance;

	fvac_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fvac_step u_step (
		.cur   (state_q),
		.cfg   (cfg),
		.frame (frame_s1),
		.nxt   (state_nxt),
		.res   (result_nxt)
	);

	// Handshake: advance the input stage when the result register is free
	assign advance        = valid_s1 && (!out_valid_q || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;
	assign accept         = frame_in.valid && frame_in.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1.target_present    <= frame_in.target_present;
			frame_s1.class_is_fatigued <= frame_in.class_is_fatigued;
			frame_s1.class_confidence  <= frame_in.class_confidence;
		end
	end

	// Controller state, updated once per processed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result_out.valid            = out_valid_q;
	assign result_out.alarm_active     = result_q.alarm_active;
	assign result_out.alarm_started    = result_q.alarm_started;
	assign result_out.alarm_ended      = result_q.alarm_ended;
	assign result_out.lost_alert       = result_q.lost_alert;
	assign result_out.target_recovered = result_q.target_recovered;
	assign result_out.led_drive        = result_q.led_drive;
	assign result_out.frame_vote       = result_q.frame_vote;
	assign result_out.window_votes     = result_q.window_votes;
	assign result_out.current_score    = result_q.current_score;
	assign result_out.current_streak   = result_q.current_streak;

	// Checks
	`FVAC_ASSERT_NOW(a_total_matches_window, clk, arst_n, 1'b1, $countones(state_q.vote_window) == int'(state_q.vote_total), "vote total out of step with window")
	`FVAC_ASSERT_NOW(a_score_bounded, clk, arst_n, 1'b1, state_q.score <= SCORE_W'(SCORE_MAX), "score above maximum")
	`FVAC_ASSERT_NOW(a_start_end_excl, clk, arst_n, out_valid_q, !(result_q.alarm_started && result_q.alarm_ended), "alarm started and ended together")
	`FVAC_ASSERT_NOW(a_start_active, clk, arst_n, out_valid_q && result_q.alarm_started, result_q.alarm_active, "alarm started but not active")
	`FVAC_ASSERT_NOW(a_stall_cause, clk, arst_n, !frame_in.ready, valid_s1 && out_valid_q && !result_out.ready, "input stalled without a full pipeline")
	`FVAC_ASSERT_NEXT(a_advance_result, clk, arst_n, advance, out_valid_q, "processed frame left no result")

endmodule

@@ rtl/core/fvac_cfg_regs.sv @@
module fvac_cfg_regs
	import fvac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Decode writes into the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confidence_threshold <= 8'd179;
			cfg_q.warmup_frames        <= 10'd60;
			cfg_q.alarm_ratio_percent  <= 7'd60;
			cfg_q.score_rise           <= 10'd20;
			cfg_q.score_decay          <= 10'd5;
			cfg_q.danger_score         <= 10'd500;
			cfg_q.streak_threshold     <= 8'd10;
			cfg_q.alarm_length         <= 16'd90;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CONF_THR:     cfg_q.confidence_threshold <= wr_data[7:0];
				REG_WARMUP:       cfg_q.warmup_frames        <= wr_data[9:0];
				REG_RATIO:        cfg_q.alarm_ratio_percent  <= wr_data[6:0];
				REG_SCORE_RISE:   cfg_q.score_rise           <= wr_data[9:0];
				REG_SCORE_DECAY:  cfg_q.score_decay          <= wr_data[9:0];
				REG_DANGER:       cfg_q.danger_score         <= wr_data[9:0];
				REG_STREAK_THR:   cfg_q.streak_threshold     <= wr_data[7:0];
				REG_ALARM_LENGTH: cfg_q.alarm_length         <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/fvac_step.sv @@
module fvac_step
	import fvac_pkg::*;
(
	input  state_t  cur,
	input  cfg_t    cfg,
	input  frame_t  frame,
	output state_t  nxt,
	output result_t res
);

	logic [7:0]         phase_inc;
	logic               blink_now;
	logic [15:0]        lost_inc;
	logic               vote;
	logic [7:0]         streak_n;
	logic               old_bit;
	logic [TOT_W-1:0]   total_dec;
	logic [TOT_W-1:0]   total_n;
	logic               pos_last;
	logic               full_n;
	logic [SCORE_W:0]   score_sum;
	logic [SCORE_W-1:0] score_n;
	logic [PROD_W-1:0]  vote_prod;
	logic [PROD_W-1:0]  need_prod;
	logic               ratio_ok;
	logic [15:0]        alarm_inc;
	logic               toggle_n;

	// Frame-level counters and the shared window update terms
	always_comb begin
		phase_inc = cur.blink_phase + 8'd1;
		lost_inc  = (cur.lost_frames != '1) ? cur.lost_frames + 16'd1 : cur.lost_frames;
		vote      = frame.class_is_fatigued && (frame.class_confidence >= cfg.confidence_threshold);
		if (vote)
			streak_n = (cur.fatigue_streak != '1) ? cur.fatigue_streak + 8'd1 : cur.fatigue_streak;
		else
			streak_n = '0;
		old_bit   = cur.vote_window[cur.window_position];
		total_dec = (old_bit && cur.vote_total != '0) ? cur.vote_total - TOT_W'(1) : cur.vote_total;
		total_n   = total_dec + TOT_W'(vote);
		pos_last  = (cur.window_position == POS_W'(VOTE_WINDOW - 1));
		full_n    = cur.window_full | pos_last;
		score_sum = {1'b0, cur.score} + {1'b0, cfg.score_rise};
		if (vote)
			score_n = (score_sum >= (SCORE_W+1)'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
				: score_sum[SCORE_W-1:0];
		else
			score_n = (cur.score > cfg.score_decay) ? cur.score - cfg.score_decay : '0;
		vote_prod = PROD_W'(total_n) * PROD_W'(PERCENT_FULL);
		need_prod = PROD_W'(cfg.alarm_ratio_percent) * PROD_W'(VOTE_WINDOW);
		ratio_ok  = full_n && (vote_prod >= need_prod);
		alarm_inc = (cur.alarm_frames != '1) ? cur.alarm_frames + 16'd1 : cur.alarm_frames;
		toggle_n  = !cur.toggle_bit;
	end

	// Next state and result for one frame
	always_comb begin
		nxt = cur;
		res = '0;

		if (cur.frames_seen != '1)
			nxt.frames_seen = cur.frames_seen + 11'd1;
		nxt.blink_phase = (phase_inc >= 8'(BLINK_DIV)) ? '0 : phase_inc;
		blink_now = (nxt.blink_phase == '0);

		if (!frame.target_present) begin
			// Lost target: drop votes and score, end any alarm
			nxt.lost_frames     = lost_inc;
			nxt.vote_window     = '0;
			nxt.window_position = '0;
			nxt.window_full     = 1'b0;
			nxt.vote_total      = '0;
			nxt.fatigue_streak  = '0;
			nxt.score           = '0;
			if (cur.in_alarm) begin
				nxt.in_alarm     = 1'b0;
				nxt.alarm_frames = '0;
				res.alarm_ended  = 1'b1;
			end
			if (lost_inc >= 16'(LOST_FRAMES)) begin
				if (blink_now) begin
					nxt.toggle_bit = toggle_n;
					nxt.led_levels = toggle_n ? (cur.led_levels | LED_EVEN)
						: (cur.led_levels & LED_ODD);
				end
				if (!cur.lost_reported) begin
					nxt.lost_reported = 1'b1;
					res.lost_alert    = 1'b1;
				end
			end
		end else begin
			if (cur.lost_frames >= 16'(LOST_FRAMES)) begin
				res.target_recovered = 1'b1;
				nxt.led_levels       = cur.led_levels & LED_ODD;
			end
			nxt.lost_frames    = '0;
			nxt.lost_reported  = 1'b0;
			nxt.fatigue_streak = streak_n;
			res.frame_vote     = vote;

			if (!cur.in_alarm) begin
				// Monitoring: collect the vote once warm-up is over
				if (nxt.frames_seen > {1'b0, cfg.warmup_frames}) begin
					nxt.vote_window[cur.window_position] = vote;
					nxt.vote_total      = total_n;
					nxt.window_position = pos_last ? '0 : cur.window_position + POS_W'(1);
					nxt.window_full     = full_n;
					nxt.score           = score_n;
					if (score_n >= cfg.danger_score &&
						(ratio_ok || streak_n >= cfg.streak_threshold)) begin
						nxt.in_alarm      = 1'b1;
						nxt.alarm_frames  = '0;
						res.alarm_started = 1'b1;
					end
				end
			end else begin
				// Alarm: alternate LED pairs until timeout
				nxt.alarm_frames = alarm_inc;
				nxt.toggle_bit   = toggle_n;
				nxt.led_levels   = toggle_n ? LED_ODD : LED_EVEN;
				if (alarm_inc >= cfg.alarm_length) begin
					nxt.led_levels      = '0;
					nxt.vote_window     = '0;
					nxt.window_position = '0;
					nxt.window_full     = 1'b0;
					nxt.vote_total      = '0;
					nxt.fatigue_streak  = '0;
					nxt.score           = '0;
					nxt.in_alarm        = 1'b0;
					res.alarm_ended     = 1'b1;
				end
			end
		end

		res.alarm_active   = nxt.in_alarm;
		res.led_drive      = nxt.led_levels;
		res.window_votes   = WVOTE_W'(nxt.vote_total);
		res.current_score  = nxt.score;
		res.current_streak = nxt.fatigue_streak;
	end

endmodule
